// ----- sv/thdeq_pkg.sv -----
// Shared types and constants of the twin heap double-ended queue.
package thdeq_pkg;

  localparam int VALUE_PORT_W = 32;
  localparam int SLOT_PORT_W  = 11;
  localparam int LIMIT_W      = 11;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
  localparam logic               REG_CAP_LIMIT = 1'b0;

  localparam logic HEAP_MIN = 1'b0;
  localparam logic HEAP_MAX = 1'b1;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_DEL_MIN = 3'd1,
    CMD_DEL_MAX = 3'd2,
    CMD_RD_MIN  = 3'd3,
    CMD_RD_MAX  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_DEL_ROOT,
    S_DEL_LAST,
    S_DEL_PRD,
    S_DEL_PART,
    S_SU_RD,
    S_SU_CMP,
    S_SD_RDL,
    S_SD_RDR,
    S_SD_CMP,
    S_SFIN,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_INS_MIN,
    PH_INS_MAX,
    PH_DEL_SELF,
    PH_DEL_OTHER
  } phase_e;

endpackage

// ----- sv/twin_heap_double_ended_queue.sv -----
// Twin heap double-ended priority queue: sequencer, heap memories, config port.
// The queue keeps a min heap and a max heap in two synchronous memories with
// one read port and one write port each; each entry carries its twin's slot
// in the other heap. One command word is taken at a time. A read fetches the
// entry and then finishes. An insert sifts up in the min heap and then in the
// max heap, reading and comparing the parent at each level. A delete sifts
// the root down, then moves the twin up or down in the other heap. Refused
// and unknown commands go straight to the finish state. No clearing pass runs
// after reset; the block takes commands at once.
module twin_heap_double_ended_queue #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [2:0]                           command_i,
  input  logic [thdeq_pkg::VALUE_PORT_W-1:0]   value_i,
  input  logic [thdeq_pkg::SLOT_PORT_W-1:0]    position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [thdeq_pkg::VALUE_PORT_W-1:0]   result_value_o,
  output logic [thdeq_pkg::SLOT_PORT_W-1:0]    twin_slot_o,
  output logic [1:0]                           status_o,
  output logic [thdeq_pkg::SLOT_PORT_W-1:0]    entry_count_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [thdeq_pkg::ADDR_W-1:0]         paddr,
  input  logic [thdeq_pkg::DATA_W-1:0]         pwdata,
  output logic [thdeq_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);

  localparam int SW = $clog2(CAPACITY + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int CW = (SW > thdeq_pkg::SLOT_PORT_W) ? SW : thdeq_pkg::SLOT_PORT_W;
  localparam int XW = (VW > thdeq_pkg::VALUE_PORT_W) ? VW : thdeq_pkg::VALUE_PORT_W;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [SW-1:0] t;
  } entry_t;

  function automatic logic ahead(input logic mx, input logic [VW-1:0] a,
                                 input logic [VW-1:0] b);
    return mx ? (a > b) : (a < b);
  endfunction

  thdeq_pkg::state_e state_q, state_d;
  thdeq_pkg::phase_e phase_q, phase_d;
  logic [SW-1:0] count_q, count_d;
  logic [thdeq_pkg::LIMIT_W-1:0] limit_q;
  logic out_valid_q, out_valid_d;

  logic heap_q, heap_d;
  logic up_first_q, up_first_d;
  logic moved_q, moved_d;
  logic has_r_q, has_r_d;
  logic [SW-1:0] hole_q, hole_d;
  logic [VW-1:0] m_v_q, m_v_d;
  logic [SW-1:0] m_t_q, m_t_d;
  entry_t l_q, l_d;
  logic [SW-1:0] p_q, p_d;
  logic [VW-1:0] res_v_q, res_v_d;
  logic [SW-1:0] res_t_q, res_t_d;
  thdeq_pkg::status_e res_st_q, res_st_d;
  logic fin_load;

  logic [thdeq_pkg::VALUE_PORT_W-1:0] out_rv_q;
  logic [thdeq_pkg::SLOT_PORT_W-1:0]  out_tw_q, out_cnt_q;
  logic [1:0]                         out_st_q;

  entry_t min_mem [0:CAPACITY];
  entry_t max_mem [0:CAPACITY];
  logic          mem_re  [2];
  logic [SW-1:0] mem_ra  [2];
  logic          mem_wev [2];
  logic          mem_wet [2];
  logic [SW-1:0] mem_wa  [2];
  entry_t        mem_wd  [2];
  entry_t        mem_rd_q [2];

  logic [CW-1:0] lim_ext, pos_ext;
  logic [XW-1:0] vin, res_v_x;
  logic [CW-1:0] res_t_x, cnt_x;
  logic full, range_bad, sel, oth;
  logic [SW-1:0] old_n;
  logic [SW:0] lidx, ridx, cap1, cnt1;
  entry_t rd_self, cand;
  logic [SW-1:0] cidx;

  assign lim_ext   = (CW'(limit_q) < CW'(CAPACITY)) ? CW'(limit_q) : CW'(CAPACITY);
  assign full      = CW'(count_q) >= lim_ext;
  assign pos_ext   = CW'(position_i);
  assign range_bad = (pos_ext == '0) || (pos_ext > CW'(count_q));
  assign vin       = XW'(value_i);
  assign old_n     = count_q + SW'(1);
  assign lidx      = {hole_q, 1'b0};
  assign ridx      = {hole_q, 1'b1};
  assign cap1      = (SW + 1)'(CAPACITY);
  assign cnt1      = (SW + 1)'(count_q);
  assign oth       = ~heap_q;
  assign rd_self   = mem_rd_q[heap_q];
  assign res_v_x   = XW'(res_v_q);
  assign res_t_x   = CW'(res_t_q);
  assign cnt_x     = CW'(count_q);

  assign in_stall_o     = (state_q != thdeq_pkg::S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_rv_q;
  assign twin_slot_o    = out_tw_q;
  assign status_o       = out_st_q;
  assign entry_count_o  = out_cnt_q;
  assign pready         = 1'b1;
  assign prdata = (paddr[2] == thdeq_pkg::REG_CAP_LIMIT) ?
                  thdeq_pkg::DATA_W'(limit_q) : '0;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    count_d    = count_q;
    heap_d     = heap_q;
    up_first_d = up_first_q;
    moved_d    = moved_q;
    has_r_d    = has_r_q;
    hole_d     = hole_q;
    m_v_d      = m_v_q;
    m_t_d      = m_t_q;
    l_d        = l_q;
    p_d        = p_q;
    res_v_d    = res_v_q;
    res_t_d    = res_t_q;
    res_st_d   = res_st_q;
    fin_load   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    sel        = 1'b0;
    cand       = l_q;
    cidx       = lidx[SW-1:0];
    for (int k = 0; k < 2; k++) begin
      mem_re[k]  = 1'b0;
      mem_ra[k]  = '0;
      mem_wev[k] = 1'b0;
      mem_wet[k] = 1'b0;
      mem_wa[k]  = '0;
      mem_wd[k]  = '0;
    end

    unique case (state_q)
      thdeq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          res_v_d  = '0;
          res_t_d  = '0;
          res_st_d = thdeq_pkg::ST_DONE;
          state_d  = thdeq_pkg::S_FIN;
          unique case (command_i) inside
            thdeq_pkg::CMD_INSERT: begin
              if (full) begin
                res_st_d = thdeq_pkg::ST_FULL;
              end else begin
                count_d    = count_q + SW'(1);
                heap_d     = thdeq_pkg::HEAP_MIN;
                hole_d     = count_q + SW'(1);
                m_v_d      = vin[VW-1:0];
                m_t_d      = count_q + SW'(1);
                up_first_d = 1'b0;
                moved_d    = 1'b0;
                phase_d    = thdeq_pkg::PH_INS_MIN;
                state_d    = thdeq_pkg::S_SU_RD;
              end
            end
            thdeq_pkg::CMD_DEL_MIN, thdeq_pkg::CMD_DEL_MAX: begin
              if (count_q == '0) begin
                res_st_d = thdeq_pkg::ST_EMPTY;
              end else begin
                sel         = (command_i == thdeq_pkg::CMD_DEL_MAX);
                heap_d      = sel;
                count_d     = count_q - SW'(1);
                mem_re[sel] = 1'b1;
                mem_ra[sel] = SW'(1);
                state_d     = thdeq_pkg::S_DEL_ROOT;
              end
            end
            thdeq_pkg::CMD_RD_MIN, thdeq_pkg::CMD_RD_MAX: begin
              if (range_bad) begin
                res_st_d = thdeq_pkg::ST_RANGE;
              end else begin
                sel         = (command_i == thdeq_pkg::CMD_RD_MAX);
                heap_d      = sel;
                mem_re[sel] = 1'b1;
                mem_ra[sel] = pos_ext[SW-1:0];
                state_d     = thdeq_pkg::S_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      thdeq_pkg::S_RD_WAIT: begin
        res_v_d = rd_self.v;
        res_t_d = rd_self.t;
        state_d = thdeq_pkg::S_FIN;
      end
      thdeq_pkg::S_DEL_ROOT: begin
        res_v_d        = rd_self.v;
        p_d            = rd_self.t;
        mem_re[heap_q] = 1'b1;
        mem_ra[heap_q] = old_n;
        state_d        = thdeq_pkg::S_DEL_LAST;
      end
      thdeq_pkg::S_DEL_LAST: begin
        m_v_d = rd_self.v;
        m_t_d = rd_self.t;
        if (count_q != '0) begin
          hole_d  = SW'(1);
          phase_d = thdeq_pkg::PH_DEL_SELF;
          state_d = thdeq_pkg::S_SD_RDL;
        end else begin
          state_d = thdeq_pkg::S_FIN;
        end
      end
      thdeq_pkg::S_DEL_PRD: begin
        mem_re[heap_q] = 1'b1;
        mem_ra[heap_q] = old_n;
        state_d        = thdeq_pkg::S_DEL_PART;
      end
      thdeq_pkg::S_DEL_PART: begin
        m_v_d      = rd_self.v;
        m_t_d      = rd_self.t;
        hole_d     = p_q;
        up_first_d = 1'b1;
        moved_d    = 1'b0;
        phase_d    = thdeq_pkg::PH_DEL_OTHER;
        state_d    = thdeq_pkg::S_SU_RD;
      end
      thdeq_pkg::S_SU_RD: begin
        if (hole_q > SW'(1)) begin
          mem_re[heap_q] = 1'b1;
          mem_ra[heap_q] = hole_q >> 1;
          state_d        = thdeq_pkg::S_SU_CMP;
        end else if (up_first_q && !moved_q) begin
          state_d = thdeq_pkg::S_SD_RDL;
        end else begin
          state_d = thdeq_pkg::S_SFIN;
        end
      end
      thdeq_pkg::S_SU_CMP: begin
        if (ahead(heap_q, m_v_q, rd_self.v)) begin
          mem_wev[heap_q] = 1'b1;
          mem_wet[heap_q] = 1'b1;
          mem_wa[heap_q]  = hole_q;
          mem_wd[heap_q]  = rd_self;
          mem_wet[oth]    = 1'b1;
          mem_wa[oth]     = rd_self.t;
          mem_wd[oth].t   = hole_q;
          hole_d          = hole_q >> 1;
          moved_d         = 1'b1;
          state_d         = thdeq_pkg::S_SU_RD;
        end else if (up_first_q && !moved_q) begin
          state_d = thdeq_pkg::S_SD_RDL;
        end else begin
          state_d = thdeq_pkg::S_SFIN;
        end
      end
      thdeq_pkg::S_SD_RDL: begin
        if (lidx <= cnt1 && lidx <= cap1) begin
          mem_re[heap_q] = 1'b1;
          mem_ra[heap_q] = lidx[SW-1:0];
          state_d        = thdeq_pkg::S_SD_RDR;
        end else begin
          state_d = thdeq_pkg::S_SFIN;
        end
      end
      thdeq_pkg::S_SD_RDR: begin
        l_d     = rd_self;
        has_r_d = (ridx <= cnt1 && ridx <= cap1);
        if (ridx <= cnt1 && ridx <= cap1) begin
          mem_re[heap_q] = 1'b1;
          mem_ra[heap_q] = ridx[SW-1:0];
        end
        state_d = thdeq_pkg::S_SD_CMP;
      end
      thdeq_pkg::S_SD_CMP: begin
        if (has_r_q && !ahead(heap_q, l_q.v, rd_self.v)) begin
          cand = rd_self;
          cidx = ridx[SW-1:0];
        end
        if (ahead(heap_q, cand.v, m_v_q)) begin
          mem_wev[heap_q] = 1'b1;
          mem_wet[heap_q] = 1'b1;
          mem_wa[heap_q]  = hole_q;
          mem_wd[heap_q]  = cand;
          mem_wet[oth]    = 1'b1;
          mem_wa[oth]     = cand.t;
          mem_wd[oth].t   = hole_q;
          hole_d          = cidx;
          state_d         = thdeq_pkg::S_SD_RDL;
        end else begin
          state_d = thdeq_pkg::S_SFIN;
        end
      end
      thdeq_pkg::S_SFIN: begin
        mem_wev[heap_q]  = 1'b1;
        mem_wet[heap_q]  = 1'b1;
        mem_wa[heap_q]   = hole_q;
        mem_wd[heap_q].v = m_v_q;
        mem_wd[heap_q].t = m_t_q;
        mem_wet[oth]     = 1'b1;
        mem_wa[oth]      = m_t_q;
        mem_wd[oth].t    = hole_q;
        state_d          = thdeq_pkg::S_FIN;
        unique case (phase_q)
          thdeq_pkg::PH_INS_MIN: begin
            heap_d     = thdeq_pkg::HEAP_MAX;
            hole_d     = count_q;
            m_t_d      = hole_q;
            up_first_d = 1'b0;
            moved_d    = 1'b0;
            phase_d    = thdeq_pkg::PH_INS_MAX;
            state_d    = thdeq_pkg::S_SU_RD;
          end
          thdeq_pkg::PH_DEL_SELF: begin
            if (p_q != '0 && p_q <= count_q) begin
              heap_d  = oth;
              state_d = thdeq_pkg::S_DEL_PRD;
            end
          end
          default: ;
        endcase
      end
      thdeq_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          fin_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = thdeq_pkg::S_IDLE;
        end
      end
      default: state_d = thdeq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= thdeq_pkg::S_IDLE;
      phase_q     <= thdeq_pkg::PH_INS_MIN;
      count_q     <= '0;
      limit_q     <= thdeq_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
      heap_q      <= thdeq_pkg::HEAP_MIN;
      up_first_q  <= 1'b0;
      moved_q     <= 1'b0;
      has_r_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      heap_q      <= heap_d;
      up_first_q  <= up_first_d;
      moved_q     <= moved_d;
      has_r_q     <= has_r_d;
      if (psel && penable && pwrite && paddr[2] == thdeq_pkg::REG_CAP_LIMIT) begin
        limit_q <= pwdata[thdeq_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q   <= hole_d;
    m_v_q    <= m_v_d;
    m_t_q    <= m_t_d;
    l_q      <= l_d;
    p_q      <= p_d;
    res_v_q  <= res_v_d;
    res_t_q  <= res_t_d;
    res_st_q <= res_st_d;
    if (fin_load) begin
      out_rv_q  <= res_v_x[thdeq_pkg::VALUE_PORT_W-1:0];
      out_tw_q  <= res_t_x[thdeq_pkg::SLOT_PORT_W-1:0];
      out_st_q  <= res_st_q;
      out_cnt_q <= cnt_x[thdeq_pkg::SLOT_PORT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re[0]) mem_rd_q[0] <= min_mem[mem_ra[0]];
    if (mem_wev[0]) min_mem[mem_wa[0]].v <= mem_wd[0].v;
    if (mem_wet[0]) min_mem[mem_wa[0]].t <= mem_wd[0].t;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re[1]) mem_rd_q[1] <= max_mem[mem_ra[1]];
    if (mem_wev[1]) max_mem[mem_wa[1]].v <= mem_wd[1].v;
    if (mem_wet[1]) max_mem[mem_wa[1]].t <= mem_wd[1].t;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(count_q) <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_word_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == thdeq_pkg::S_FIN))
    else $error("result word raised outside finish");

  a_hole_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == thdeq_pkg::S_SU_CMP || state_q == thdeq_pkg::S_SD_RDL ||
     state_q == thdeq_pkg::S_SD_CMP || state_q == thdeq_pkg::S_SFIN) |-> hole_q != '0)
    else $error("sift hole at slot zero");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && command_i == thdeq_pkg::CMD_INSERT && !full)
    |=> count_q == $past(count_q) + SW'(1))
    else $error("insert did not grow count");
`endif

endmodule

// ----- dv/twin_heap_double_ended_queue_tb.sv -----
// Testbench for the twin heap double-ended queue: directed and random commands checked against a predictor.
`timescale 1ns / 100ps
module twin_heap_double_ended_queue_tb;

  localparam int CAP = 1024;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] value;
    logic [10:0] position;
  } cmd_word_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [10:0] twin_slot;
    logic [1:0]  status;
    logic [10:0] entry_count;
  } resp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] command_i = '0;
  logic [31:0] value_i = '0;
  logic [10:0] position_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] result_value_o;
  logic [10:0] twin_slot_o;
  logic [1:0] status_o;
  logic [10:0] entry_count_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [thdeq_pkg::ADDR_W-1:0] paddr = '0;
  logic [thdeq_pkg::DATA_W-1:0] pwdata = '0;
  logic [thdeq_pkg::DATA_W-1:0] prdata;
  logic pready;

  twin_heap_double_ended_queue uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] mn_val [1:CAP];
  logic [10:0] mn_tw  [1:CAP];
  logic [31:0] mx_val [1:CAP];
  logic [10:0] mx_tw  [1:CAP];
  int unsigned held = 0;
  int unsigned cap_limit = CAP;

  cmd_word_t  pending_cmds[$];
  resp_word_t expected_resps[$];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_off = 0;

  function automatic bit is_ahead(bit is_max, logic [31:0] a, logic [31:0] b);
    return is_max ? (a > b) : (a < b);
  endfunction

  function automatic void put_twin(bit other_max, int slot, logic [10:0] tw);
    if (slot >= 1 && slot <= CAP) begin
      if (other_max) mx_tw[slot] = tw;
      else mn_tw[slot] = tw;
    end
  endfunction

  function automatic void swap_at(bit hmax, int i, int j);
    logic [31:0] v;
    logic [10:0] t;
    if (hmax) begin
      v = mx_val[i]; t = mx_tw[i];
      mx_val[i] = mx_val[j]; mx_tw[i] = mx_tw[j];
      mx_val[j] = v; mx_tw[j] = t;
      put_twin(0, mx_tw[i], i[10:0]);
      put_twin(0, mx_tw[j], j[10:0]);
    end else begin
      v = mn_val[i]; t = mn_tw[i];
      mn_val[i] = mn_val[j]; mn_tw[i] = mn_tw[j];
      mn_val[j] = v; mn_tw[j] = t;
      put_twin(1, mn_tw[i], i[10:0]);
      put_twin(1, mn_tw[j], j[10:0]);
    end
  endfunction

  function automatic logic [31:0] val_at(bit hmax, int i);
    return hmax ? mx_val[i] : mn_val[i];
  endfunction

  function automatic void bubble_up(bit hmax, int i);
    while (i > 1 && i <= CAP) begin
      if (!is_ahead(hmax, val_at(hmax, i), val_at(hmax, i / 2))) break;
      swap_at(hmax, i, i / 2);
      i = i / 2;
    end
  endfunction

  function automatic void bubble_down(bit hmax, int i, int n);
    int l, r, c;
    while (i >= 1) begin
      l = 2 * i; r = 2 * i + 1;
      if (l > n || l > CAP) break;
      c = l;
      if (r <= n && r <= CAP && !is_ahead(hmax, val_at(hmax, l), val_at(hmax, r))) c = r;
      if (!is_ahead(hmax, val_at(hmax, c), val_at(hmax, i))) break;
      swap_at(hmax, c, i);
      i = c;
    end
  endfunction

  function automatic logic [31:0] pop_root(bit hmax);
    int old_n, n, p;
    logic [31:0] rv;
    old_n = held; n = old_n - 1;
    rv = val_at(hmax, 1);
    if (hmax) begin
      p = mx_tw[1];
      mx_val[1] = mx_val[old_n]; mx_tw[1] = mx_tw[old_n];
    end else begin
      p = mn_tw[1];
      mn_val[1] = mn_val[old_n]; mn_tw[1] = mn_tw[old_n];
    end
    held = n;
    if (n >= 1) begin
      put_twin(!hmax, hmax ? mx_tw[1] : mn_tw[1], 11'd1);
      bubble_down(hmax, 1, n);
    end
    if (p >= 1 && p <= n) begin
      if (hmax) begin
        mn_val[p] = mn_val[old_n]; mn_tw[p] = mn_tw[old_n];
        put_twin(1, mn_tw[p], p[10:0]);
      end else begin
        mx_val[p] = mx_val[old_n]; mx_tw[p] = mx_tw[old_n];
        put_twin(0, mx_tw[p], p[10:0]);
      end
      if (p > 1 && is_ahead(!hmax, val_at(!hmax, p), val_at(!hmax, p / 2)))
        bubble_up(!hmax, p);
      else
        bubble_down(!hmax, p, n);
    end
    return rv;
  endfunction

  function automatic resp_word_t predict_queue(cmd_word_t c);
    resp_word_t r;
    int unsigned lim;
    r = '0;
    lim = cap_limit < CAP ? cap_limit : CAP;
    case (c.command)
      thdeq_pkg::CMD_INSERT: begin
        if (held >= lim) r.status = thdeq_pkg::ST_FULL;
        else begin
          held++;
          mn_val[held] = c.value; mn_tw[held] = held[10:0];
          mx_val[held] = c.value; mx_tw[held] = held[10:0];
          bubble_up(0, held);
          bubble_up(1, held);
        end
      end
      thdeq_pkg::CMD_DEL_MIN, thdeq_pkg::CMD_DEL_MAX: begin
        if (held == 0) r.status = thdeq_pkg::ST_EMPTY;
        else r.result_value = pop_root(c.command == thdeq_pkg::CMD_DEL_MAX);
      end
      thdeq_pkg::CMD_RD_MIN, thdeq_pkg::CMD_RD_MAX: begin
        if (c.position == 0 || c.position > held) r.status = thdeq_pkg::ST_RANGE;
        else if (c.command == thdeq_pkg::CMD_RD_MIN) begin
          r.result_value = mn_val[c.position]; r.twin_slot = mn_tw[c.position];
        end else begin
          r.result_value = mx_val[c.position]; r.twin_slot = mx_tw[c.position];
        end
      end
      default: ;
    endcase
    r.entry_count = held[10:0];
    return r;
  endfunction

  // driver
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    bit fire;
    if (rst_ni) begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        expected_resps.push_back(predict_queue({command_i, value_i, position_i}));
        void'(pending_cmds.pop_front());
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end
      if (!in_valid_i || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_valid_i <= 1'b1;
          command_i <= pending_cmds[0].command;
          value_i <= pending_cmds[0].value;
          position_i <= pending_cmds[0].position;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin
    resp_word_t got, exp_r;
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && !out_stall_i) begin
        got = {result_value_o, twin_slot_o, status_o, entry_count_o};
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_resps.pop_front();
          if (got.result_value !== exp_r.result_value) begin
            $display("%0t: result_value exp %h got %h", $time, exp_r.result_value,
                     got.result_value);
            errors++;
          end
          if (got.twin_slot !== exp_r.twin_slot) begin
            $display("%0t: twin_slot exp %0d got %0d", $time, exp_r.twin_slot, got.twin_slot);
            errors++;
          end
          if (got.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
            errors++;
          end
          if (got.entry_count !== exp_r.entry_count) begin
            $display("%0t: entry_count exp %0d got %0d", $time, exp_r.entry_count,
                     got.entry_count);
            errors++;
          end
        end
        recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      if (cycles > 2000000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic add_cmd(logic [2:0] c, logic [31:0] v, logic [10:0] p);
    pending_cmds.push_back('{command: c, value: v, position: p});
  endtask

  task automatic write_limit(logic [10:0] lim);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {21'd0, lim};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cap_limit = lim;
  endtask

  task automatic drain;
    while (pending_cmds.size() > 0 || in_valid_i || expected_resps.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int count, int depth);
    int k;
    logic [2:0] c;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c = thdeq_pkg::CMD_INSERT;
        4, 5: c = thdeq_pkg::CMD_DEL_MIN;
        6, 7: c = thdeq_pkg::CMD_DEL_MAX;
        8: c = $urandom_range(0, 1) ? thdeq_pkg::CMD_RD_MIN : thdeq_pkg::CMD_RD_MAX;
        default: c = $urandom_range(0, 20) == 0 ? 3'($urandom_range(5, 7)) :
                     thdeq_pkg::CMD_RD_MAX;
      endcase
      add_cmd(c, pick_value(),
              $urandom_range(0, 15) == 0 ? 11'($urandom) : 11'($urandom_range(0, depth)));
    end
  endtask

  initial begin
    int k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty deletes, bad reads, extremes, ties, unknown codes
    add_cmd(thdeq_pkg::CMD_DEL_MIN, 32'hFFFF_FFFF, 11'h7FF);
    add_cmd(thdeq_pkg::CMD_DEL_MAX, 32'd0, 11'd0);
    add_cmd(thdeq_pkg::CMD_RD_MIN, 32'd0, 11'd1);
    add_cmd(thdeq_pkg::CMD_RD_MAX, 32'd0, 11'd0);
    add_cmd(thdeq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 11'h7FF);
    add_cmd(thdeq_pkg::CMD_INSERT, 32'd0, 11'd0);
    add_cmd(thdeq_pkg::CMD_INSERT, 32'h5555_AAAA, 11'd0);
    add_cmd(thdeq_pkg::CMD_INSERT, 32'h5555_AAAA, 11'd0);
    add_cmd(thdeq_pkg::CMD_INSERT, 32'hAAAA_5555, 11'd0);
    for (k = 1; k <= 6; k++)
      add_cmd(k % 2 ? thdeq_pkg::CMD_RD_MIN : thdeq_pkg::CMD_RD_MAX, 32'd0, k[10:0]);
    add_cmd(3'd5, 32'd1, 11'd1); add_cmd(3'd6, 32'd1, 11'd1); add_cmd(3'd7, 32'd1, 11'd1);
    add_cmd(thdeq_pkg::CMD_RD_MAX, 32'd0, 11'h7FF);
    add_cmd(thdeq_pkg::CMD_DEL_MAX, 32'd0, 11'd0);
    add_cmd(thdeq_pkg::CMD_DEL_MIN, 32'd0, 11'd0);
    add_cmd(thdeq_pkg::CMD_DEL_MIN, 32'd0, 11'd0);
    add_cmd(thdeq_pkg::CMD_DEL_MAX, 32'd0, 11'd0);
    add_cmd(thdeq_pkg::CMD_DEL_MIN, 32'd0, 11'd0);
    add_cmd(thdeq_pkg::CMD_DEL_MIN, 32'd0, 11'd0);
    drain();
    // limit 1
    write_limit(11'd1);
    random_phase(60, 2);
    drain();
    // limit 0 refuses every insert
    write_limit(11'd0);
    random_phase(20, 2);
    drain();
    // big limit, word 11'h7FF clamps to capacity; fill with backpressure
    write_limit(11'h7FF);
    hold_off = 400;
    for (k = 0; k < 60; k++) add_cmd(thdeq_pkg::CMD_INSERT, pick_value(), 11'd0);
    random_phase(200, 70);
    drain();
    write_limit(11'd8);
    random_phase(150, 10);
    drain();
    write_limit(11'd1024);
    random_phase(250, 40);
    drain();
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
